// File: hw/rtl/tiled_cellular_noise_distance_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cellular noise distance block
// Clocked concurrent assertions, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef TILED_CELLULAR_NOISE_DISTANCE_ASSERT_SVH
`define TILED_CELLULAR_NOISE_DISTANCE_ASSERT_SVH

`define TCND_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TCND_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tcnd_pkg.sv
// ----------------------------------------------------------------------------
// tcnd_pkg
// Constants and types shared by the cellular noise distance modules.
// ----------------------------------------------------------------------------
package tcnd_pkg;

    localparam int C_COORD_INT_BITS = 16;
    localparam int C_PERIOD_W       = 15;
    localparam int C_SEED_W         = 32;
    localparam int C_DIST_W         = 17;
    localparam int C_SQ_W           = 35;
    localparam int C_CFG_IDX_W      = 2;
    localparam int C_HASH_SHIFT     = 13;

    localparam logic [31:0] C_HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] C_HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] C_HASH_MIX   = 32'd1274126177;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_HASH_SEED = 2'd0,
        CFG_PERIOD_X  = 2'd1,
        CFG_PERIOD_Y  = 2'd2
    } t_cfg_idx;

    // Neighbor cell hash inputs, index 0 is offset -1, index 2 is offset +1
    typedef struct packed {
        logic [2:0][31:0] hx;
        logic [2:0][31:0] hy;
        logic [15:0]      fx;
        logic [15:0]      fy;
    } t_cells;

endpackage

// File: hw/rtl/tiled_cellular_noise_distance.sv
// ----------------------------------------------------------------------------
// tiled_cellular_noise_distance
// Distance to the nearest feature point of the 3x3 neighbor cells, tiled.
// Pipeline: index reduction, hash, square root.
// Throughput: one transaction per cycle; the whole pipeline holds on a stall.
// Reset: synchronous active low; clears valid bits and configuration registers.
// ----------------------------------------------------------------------------
module tiled_cellular_noise_distance #(
    parameter int COORD_INT_BITS = tcnd_pkg::C_COORD_INT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tcnd_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [31:0]                   i_point_x,
    input  logic signed [31:0]                   i_point_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tcnd_pkg::C_DIST_W-1:0]        o_nearest_distance
);
    import tcnd_pkg::*;

    logic [C_SEED_W-1:0]   r_seed;
    logic [C_PERIOD_W-1:0] r_period_x;
    logic [C_PERIOD_W-1:0] r_period_y;

    logic              en;
    logic              wrap_v, hash_v;
    t_cells            cells;
    logic [C_SQ_W-1:0] dist_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_period_x <= '0;
            r_period_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HASH_SEED: r_seed     <= i_cfg_data;
                CFG_PERIOD_X:  r_period_x <= i_cfg_data[C_PERIOD_W-1:0];
                CFG_PERIOD_Y:  r_period_y <= i_cfg_data[C_PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    tcnd_wrap #(
        .COORD_INT_BITS(COORD_INT_BITS)
    ) u_wrap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_period_x (r_period_x),
        .i_period_y (r_period_y),
        .o_valid    (wrap_v),
        .o_cells    (cells)
    );

    tcnd_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (wrap_v),
        .i_cells   (cells),
        .i_seed    (r_seed),
        .o_valid   (hash_v),
        .o_dist_sq (dist_sq)
    );

    tcnd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hash_v),
        .i_value (dist_sq),
        .o_valid (o_out_valid),
        .o_root  (o_nearest_distance)
    );

endmodule

// File: hw/rtl/tcnd_wrap.sv
// ----------------------------------------------------------------------------
// tcnd_wrap
// Split sample coordinates, reduce cell indices modulo the tiling period one
// bit per stage, and form the three neighbor indices on each axis.
// ----------------------------------------------------------------------------
module tcnd_wrap #(
    parameter int COORD_INT_BITS = tcnd_pkg::C_COORD_INT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic [tcnd_pkg::C_PERIOD_W-1:0]   i_period_x,
    input  logic [tcnd_pkg::C_PERIOD_W-1:0]   i_period_y,
    output logic                              o_valid,
    output tcnd_pkg::t_cells                  o_cells
);
    import tcnd_pkg::*;

    localparam int CIB = COORD_INT_BITS;
    localparam int FB  = 32 - COORD_INT_BITS;
    localparam int PW  = C_PERIOD_W;

    function automatic logic [PW-1:0] rem_step(input logic [PW-1:0] rem,
                                               input logic b,
                                               input logic [PW-1:0] p);
        logic [PW:0] t;
        t = {rem, b};
        if (t >= {1'b0, p}) begin
            t = t - {1'b0, p};
        end
        return t[PW-1:0];
    endfunction

    logic signed [CIB-1:0] cx, cy;
    logic [15:0]           fx, fy;
    logic [CIB-1:0]        ax, ay;

    assign cx = i_point_x[31 -: CIB];
    assign cy = i_point_y[31 -: CIB];
    assign ax = cx[CIB-1] ? CIB'(-cx) : CIB'(cx);
    assign ay = cy[CIB-1] ? CIB'(-cy) : CIB'(cy);

    generate
        if (FB >= 16) begin : g_fine
            assign fx = i_point_x[FB-1 -: 16];
            assign fy = i_point_y[FB-1 -: 16];
        end else if (FB > 0) begin : g_coarse
            assign fx = {i_point_x[FB-1:0], {(16-FB){1'b0}}};
            assign fy = {i_point_y[FB-1:0], {(16-FB){1'b0}}};
        end else begin : g_none
            assign fx = '0;
            assign fy = '0;
        end
    endgenerate

    logic [CIB:0]          r_v;
    logic [PW-1:0]         r_rx [0:CIB];
    logic [PW-1:0]         r_ry [0:CIB];
    logic [CIB-1:0]        r_ax [0:CIB];
    logic [CIB-1:0]        r_ay [0:CIB];
    logic signed [CIB-1:0] r_cx [0:CIB];
    logic signed [CIB-1:0] r_cy [0:CIB];
    logic [15:0]           r_fx [0:CIB];
    logic [15:0]           r_fy [0:CIB];

    logic                  r_mv;
    logic [PW-1:0]         r_mx, r_my;
    logic signed [CIB-1:0] r_mcx, r_mcy;
    logic [15:0]           r_mfx, r_mfy;

    logic                  r_nv;
    t_cells                r_cells;
    t_cells                n_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_mv <= 1'b0;
            r_nv <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[CIB-1:0], i_valid};
            r_mv <= r_v[CIB];
            r_nv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0] <= '0;
            r_ry[0] <= '0;
            r_ax[0] <= ax;
            r_ay[0] <= ay;
            r_cx[0] <= cx;
            r_cy[0] <= cy;
            r_fx[0] <= fx;
            r_fy[0] <= fy;
            for (int s = 0; s < CIB; s++) begin
                r_rx[s+1] <= rem_step(r_rx[s], r_ax[s][CIB-1], i_period_x);
                r_ry[s+1] <= rem_step(r_ry[s], r_ay[s][CIB-1], i_period_y);
                r_ax[s+1] <= r_ax[s] << 1;
                r_ay[s+1] <= r_ay[s] << 1;
                r_cx[s+1] <= r_cx[s];
                r_cy[s+1] <= r_cy[s];
                r_fx[s+1] <= r_fx[s];
                r_fy[s+1] <= r_fy[s];
            end
            r_mx  <= (r_cx[CIB][CIB-1] && r_rx[CIB] != '0) ? i_period_x - r_rx[CIB]
                                                           : r_rx[CIB];
            r_my  <= (r_cy[CIB][CIB-1] && r_ry[CIB] != '0) ? i_period_y - r_ry[CIB]
                                                           : r_ry[CIB];
            r_mcx <= r_cx[CIB];
            r_mcy <= r_cy[CIB];
            r_mfx <= r_fx[CIB];
            r_mfy <= r_fy[CIB];
            r_cells <= n_cells;
        end
    end

    always_comb begin
        logic [31:0] ex_x, ex_y;
        ex_x = 32'(r_mcx);
        ex_y = 32'(r_mcy);
        n_cells.fx = r_mfx;
        n_cells.fy = r_mfy;
        if (i_period_x == '0) begin
            n_cells.hx[0] = ex_x - 32'd1;
            n_cells.hx[1] = ex_x;
            n_cells.hx[2] = ex_x + 32'd1;
        end else begin
            n_cells.hx[0] = 32'((r_mx == '0) ? i_period_x - PW'(1) : r_mx - PW'(1));
            n_cells.hx[1] = 32'(r_mx);
            n_cells.hx[2] = 32'(({1'b0, r_mx} + 16'd1 == {1'b0, i_period_x}) ? '0
                                : r_mx + PW'(1));
        end
        if (i_period_y == '0) begin
            n_cells.hy[0] = ex_y - 32'd1;
            n_cells.hy[1] = ex_y;
            n_cells.hy[2] = ex_y + 32'd1;
        end else begin
            n_cells.hy[0] = 32'((r_my == '0) ? i_period_y - PW'(1) : r_my - PW'(1));
            n_cells.hy[1] = 32'(r_my);
            n_cells.hy[2] = 32'(({1'b0, r_my} + 16'd1 == {1'b0, i_period_y}) ? '0
                                : r_my + PW'(1));
        end
    end

    assign o_valid = r_nv;
    assign o_cells = r_cells;

endmodule

// File: hw/rtl/tcnd_hash.sv
// ----------------------------------------------------------------------------
// tcnd_hash
// Hash the nine neighbor cells into feature points, form squared distances
// and reduce them to the minimum.
// ----------------------------------------------------------------------------
module tcnd_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  tcnd_pkg::t_cells                i_cells,
    input  logic [tcnd_pkg::C_SEED_W-1:0]   i_seed,
    output logic                            o_valid,
    output logic [tcnd_pkg::C_SQ_W-1:0]     o_dist_sq
);
    import tcnd_pkg::*;

    logic [7:0]         r_v;
    logic [31:0]        r_px [0:2];
    logic [31:0]        r_py [0:2];
    logic [31:0]        r_hm [0:8];
    logic [31:0]        r_h  [0:8];
    logic signed [18:0] r_ex [0:8];
    logic signed [18:0] r_ey [0:8];
    logic [33:0]        r_sqx [0:8];
    logic [33:0]        r_sqy [0:8];
    logic [C_SQ_W-1:0]  r_d  [0:8];
    logic [C_SQ_W-1:0]  r_m3 [0:2];
    logic [C_SQ_W-1:0]  r_min;
    logic [15:0]        r_fx [0:2];
    logic [15:0]        r_fy [0:2];

    logic [31:0]        n_h0 [0:8];
    logic signed [18:0] n_ex [0:8];
    logic signed [18:0] n_ey [0:8];
    logic signed [37:0] n_qx [0:8];
    logic signed [37:0] n_qy [0:8];

    function automatic logic [C_SQ_W-1:0] min3(input logic [C_SQ_W-1:0] a,
                                               input logic [C_SQ_W-1:0] b,
                                               input logic [C_SQ_W-1:0] c);
        logic [C_SQ_W-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_h0[i] = r_px[i % 3] + r_py[i / 3] + i_seed;
            n_ex[i] = $signed({3'b000, r_fx[2]}) - 19'(((i % 3) - 1) * 65536)
                      - $signed({3'b000, r_h[i][15:0]});
            n_ey[i] = $signed({3'b000, r_fy[2]}) - 19'(((i / 3) - 1) * 65536)
                      - $signed({3'b000, r_h[i][31:16]});
            n_qx[i] = r_ex[i] * r_ex[i];
            n_qy[i] = r_ey[i] * r_ey[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_px[j] <= i_cells.hx[j] * C_HASH_MUL_X;
                r_py[j] <= i_cells.hy[j] * C_HASH_MUL_Y;
            end
            r_fx[0] <= i_cells.fx;
            r_fy[0] <= i_cells.fy;
            r_fx[1] <= r_fx[0];
            r_fy[1] <= r_fy[0];
            r_fx[2] <= r_fx[1];
            r_fy[2] <= r_fy[1];
            for (int i = 0; i < 9; i++) begin
                r_hm[i]  <= n_h0[i] ^ (n_h0[i] >> C_HASH_SHIFT);
                r_h[i]   <= r_hm[i] * C_HASH_MIX;
                r_ex[i]  <= n_ex[i];
                r_ey[i]  <= n_ey[i];
                r_sqx[i] <= n_qx[i][33:0];
                r_sqy[i] <= n_qy[i][33:0];
                r_d[i]   <= {1'b0, r_sqx[i]} + {1'b0, r_sqy[i]};
            end
            for (int g = 0; g < 3; g++) begin
                r_m3[g] <= min3(r_d[3*g], r_d[3*g+1], r_d[3*g+2]);
            end
            r_min <= min3(r_m3[0], r_m3[1], r_m3[2]);
        end
    end

    assign o_valid   = r_v[7];
    assign o_dist_sq = r_min;

endmodule

// File: hw/rtl/tcnd_isqrt.sv
// ----------------------------------------------------------------------------
// tcnd_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tcnd_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [tcnd_pkg::C_SQ_W-1:0]     i_value,
    output logic                            o_valid,
    output logic [tcnd_pkg::C_DIST_W-1:0]   o_root
);
    import tcnd_pkg::*;

    localparam int NSTG = (C_SQ_W + 1) / 2;
    localparam int RW   = C_SQ_W + 1;

    logic [NSTG-1:0]   r_v;
    logic [C_SQ_W-1:0] r_rem [0:NSTG-1];
    logic [RW-1:0]     r_res [0:NSTG-1];

    typedef struct packed {
        logic [C_SQ_W-1:0] rem;
        logic [RW-1:0]     res;
    } t_sq_state;

    function automatic t_sq_state sq_step(input logic [C_SQ_W-1:0] rem,
                                          input logic [RW-1:0] res,
                                          input int s);
        logic [RW-1:0] b;
        logic [RW-1:0] t;
        t_sq_state     o;
        b = RW'(1) << (2 * (NSTG - 1 - s));
        t = res + b;
        if ({1'b0, rem} >= t) begin
            o.rem = rem - t[C_SQ_W-1:0];
            o.res = (res >> 1) + b;
        end else begin
            o.rem = rem;
            o.res = res >> 1;
        end
        return o;
    endfunction

    t_sq_state n_st [0:NSTG-1];

    always_comb begin
        n_st[0] = sq_step(i_value, '0, 0);
        for (int s = 1; s < NSTG; s++) begin
            n_st[s] = sq_step(r_rem[s-1], r_res[s-1], s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NSTG; s++) begin
                r_rem[s] <= n_st[s].rem;
                r_res[s] <= n_st[s].res;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_root  = r_res[NSTG-1][C_DIST_W-1:0];

endmodule

// File: hw/rtl/tcnd_checker.sv
// ----------------------------------------------------------------------------
// tcnd_checker
// Port-level checks for the cellular noise distance block.
// ----------------------------------------------------------------------------
`include "tiled_cellular_noise_distance_assert.svh"

module tcnd_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [tcnd_pkg::C_DIST_W-1:0]        o_nearest_distance
);
    import tcnd_pkg::*;

    `TCND_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")
    `TCND_ASSERT(a_hold_valid, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "valid dropped")
    `TCND_ASSERT(a_hold_data, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_nearest_distance), "data changed")
    `TCND_ASSERT(a_range, i_clk, i_rst_n, o_out_valid |-> o_nearest_distance <= 17'd92681, "distance out of range")

endmodule

bind tiled_cellular_noise_distance tcnd_checker u_tcnd_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tiled cellular noise distance block. A local
// predictor computes the nearest feature distance for every accepted
// transaction; the monitor compares results in order. Seed and periods are
// reprogrammed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
    import tcnd_pkg::*;

    localparam int INT_BITS  = C_COORD_INT_BITS;
    localparam int FRAC_BITS = 32 - INT_BITS;
    localparam int LATENCY   = INT_BITS + 29;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [C_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]            i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [31:0]     i_point_x = '0;
    logic signed [31:0]     i_point_y = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [C_DIST_W-1:0]    o_nearest_distance;

    logic [31:0] seed_q = '0;
    logic [14:0] per_x_q = '0;
    logic [14:0] per_y_q = '0;

    logic [63:0]         point_queue[$];
    logic [C_DIST_W-1:0] distance_queue[$];
    int  errors = 0;
    int  in_gap = 0;
    int  out_gap = 0;

    tiled_cellular_noise_distance #(.COORD_INT_BITS(INT_BITS)) i_dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic void split_point(input logic [31:0] raw, output longint cell_idx,
                                        output logic [15:0] frac);
        logic [31:0] biased;
        logic [31:0] f;
        biased = raw ^ 32'h8000_0000;
        f = (FRAC_BITS > 0) ? (biased & ((32'd1 << FRAC_BITS) - 1)) : 32'd0;
        cell_idx = longint'(biased >> FRAC_BITS) - (longint'(1) << (31 - FRAC_BITS));
        if (FRAC_BITS >= 16) frac = 16'(f >> (FRAC_BITS - 16));
        else frac = 16'((f << (16 - FRAC_BITS)) & 32'hFFFF);
    endfunction

    function automatic logic [31:0] tile_index(input longint v, input logic [14:0] p);
        longint m;
        if (p == 0) return v[31:0];
        m = v % longint'(p);
        if (m < 0) m += longint'(p);
        return m[31:0];
    endfunction

    function automatic logic [C_DIST_W-1:0] nearest_distance(input logic [63:0] pt);
        longint xi, yi, ex, ey;
        logic [15:0] fx, fy;
        logic [31:0] h;
        logic [63:0] d, best, v, res, b;
        best = '1;
        split_point(pt[31:0], xi, fx);
        split_point(pt[63:32], yi, fy);
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                h = tile_index(xi + dx, per_x_q) * C_HASH_MUL_X
                    + tile_index(yi + dy, per_y_q) * C_HASH_MUL_Y + seed_q;
                h = (h ^ (h >> C_HASH_SHIFT)) * C_HASH_MIX;
                ex = longint'(fx) - (dx * 65536 + longint'(h[15:0]));
                ey = longint'(fy) - (dy * 65536 + longint'(h[31:16]));
                d = ex * ex + ey * ey;
                if (d < best) best = d;
            end
        end
        v = best;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res[C_DIST_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            distance_queue.push_back(nearest_distance({i_point_y, i_point_x}));
        end
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (point_queue.size() > 0 && i_rst_n) begin
                {i_point_y, i_point_x} <= point_queue.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        int gap;
        if (o_out_valid && i_out_ready) begin
            if (distance_queue.size() == 0) begin
                $display("%0t: nearest_distance expected none actual %0d",
                         $time, o_nearest_distance);
                errors++;
            end else begin
                if (distance_queue[0] !== o_nearest_distance) begin
                    $display("%0t: nearest_distance expected %0d actual %0d",
                             $time, distance_queue[0], o_nearest_distance);
                    errors++;
                end
                void'(distance_queue.pop_front());
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            out_gap <= gap;
            i_out_ready <= (gap == 0);
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= (out_gap == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_HASH_SEED: seed_q <= data;
            CFG_PERIOD_X: per_x_q <= data[14:0];
            CFG_PERIOD_Y: per_y_q <= data[14:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (point_queue.size() != 0 || i_in_valid || distance_queue.size() != 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return {{8{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 24'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] seeds[5];
        logic [14:0] pers[5];
        seeds = '{32'd0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'd1};
        pers = '{15'd0, 15'h7FFF, 15'd1, 15'd3, 15'd17};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        point_queue.push_back({32'h0, 32'h0});
        point_queue.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_queue.push_back({32'h8000_0000, 32'h8000_0000});
        point_queue.push_back({32'h8000_0000, 32'h7FFF_FFFF});
        point_queue.push_back({32'hFFFF_FFFF, 32'h0001_0000});
        point_queue.push_back({32'h0000_8000, 32'hFFFF_8000});
        point_queue.push_back({32'hFFFF_0000, 32'hFFFE_FFFF});
        point_queue.push_back({32'h5555_5555, 32'hAAAA_AAAA});
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_HASH_SEED, (ph < 5) ? seeds[ph] : $urandom());
                write_reg(CFG_PERIOD_X, (ph < 5) ? pers[ph] : $urandom_range(0, 40));
                write_reg(CFG_PERIOD_Y, (ph < 5) ? pers[4 - ph] : $urandom_range(0, 40));
            end
            for (int n = 0; n < 200; n++) point_queue.push_back({rand_coord(), rand_coord()});
            drain();
        end
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
